// File: sv/tdmq_pkg.sv
// Package for the timed deadline message queue.
// Holds request and result types, codes, controller states and commands.
// Depends on nothing.
`timescale 1ns / 1ps

package tdmq_pkg;

    localparam logic [2:0] KIND_POST   = 3'd0;
    localparam logic [2:0] KIND_TICK   = 3'd1;
    localparam logic [2:0] KIND_TAKE   = 3'd2;
    localparam logic [2:0] KIND_FINISH = 3'd3;
    localparam logic [2:0] KIND_ABORT  = 3'd4;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_POOL_EMPTY  = 2'd1;
    localparam logic [1:0] ST_READY_EMPTY = 2'd2;
    localparam logic [1:0] ST_NOT_QUEUED  = 2'd3;

    localparam logic [1:0] WHERE_FREE  = 2'd0;
    localparam logic [1:0] WHERE_TIMER = 2'd1;
    localparam logic [1:0] WHERE_READY = 2'd2;
    localparam logic [1:0] WHERE_TAKEN = 2'd3;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] now;
        logic signed [31:0] ref_baseline;
        logic signed [31:0] ref_deadline;
        logic               from_interrupt;
        logic signed [31:0] base_offset;
        logic signed [31:0] dead_offset;
        logic [2:0]         slot_in;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [2:0]         slot_out;
        logic               went_ready;
        logic signed [31:0] msg_baseline;
        logic signed [31:0] msg_deadline;
        logic               ready_nonempty;
        logic signed [31:0] ready_head_deadline;
        logic               timer_nonempty;
        logic signed [31:0] timer_head_baseline;
        logic [3:0]         released;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POST_A,
        S_POST_B,
        S_INSERT,
        S_TICK,
        S_TAKE,
        S_FINISH,
        S_ABORT_INIT,
        S_ABORT_STEP,
        S_RESULT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_POST_A,
        OP_POST_B,
        OP_INSERT,
        OP_TICK,
        OP_TAKE,
        OP_FINISH,
        OP_ABORT_INIT,
        OP_ABORT_STEP,
        OP_RESULT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       pool_empty;
        logic       insert_go;
        logic       release_go;
        logic       abort_ok;
        logic       abort_go;
        logic       out_free;
    } stat_t;

endpackage

// File: sv/tdmq_ctrl.sv
// Controller state machine for the timed deadline message queue.
// Sequences one request at a time and issues commands to tdmq_datapath.
// Depends on tdmq_pkg.
`timescale 1ns / 1ps

module tdmq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic [2:0]       item_kind,
    input  tdmq_pkg::stat_t  stat,
    output tdmq_pkg::cmd_t   cmd,
    output logic             item_stall
);

    tdmq_pkg::state_t state_reg;
    tdmq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tdmq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tdmq_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item_kind)
                        tdmq_pkg::KIND_POST:   state_next = tdmq_pkg::S_POST_A;
                        tdmq_pkg::KIND_TICK:   state_next = tdmq_pkg::S_TICK;
                        tdmq_pkg::KIND_TAKE:   state_next = tdmq_pkg::S_TAKE;
                        tdmq_pkg::KIND_FINISH: state_next = tdmq_pkg::S_FINISH;
                        tdmq_pkg::KIND_ABORT:  state_next = tdmq_pkg::S_ABORT_INIT;
                        default:               state_next = tdmq_pkg::S_RESULT;
                    endcase
                end
            end
            tdmq_pkg::S_POST_A:
            begin
                state_next = stat.pool_empty ? tdmq_pkg::S_RESULT : tdmq_pkg::S_POST_B;
            end
            tdmq_pkg::S_POST_B:
            begin
                state_next = tdmq_pkg::S_INSERT;
            end
            tdmq_pkg::S_INSERT:
            begin
                if (!stat.insert_go)
                begin
                    state_next = (stat.kind == tdmq_pkg::KIND_TICK) ?
                                 tdmq_pkg::S_TICK : tdmq_pkg::S_RESULT;
                end
            end
            tdmq_pkg::S_TICK:
            begin
                state_next = stat.release_go ? tdmq_pkg::S_INSERT : tdmq_pkg::S_RESULT;
            end
            tdmq_pkg::S_TAKE:
            begin
                state_next = tdmq_pkg::S_RESULT;
            end
            tdmq_pkg::S_FINISH:
            begin
                state_next = tdmq_pkg::S_RESULT;
            end
            tdmq_pkg::S_ABORT_INIT:
            begin
                state_next = stat.abort_ok ? tdmq_pkg::S_ABORT_STEP : tdmq_pkg::S_RESULT;
            end
            tdmq_pkg::S_ABORT_STEP:
            begin
                if (!stat.abort_go)
                begin
                    state_next = tdmq_pkg::S_RESULT;
                end
            end
            tdmq_pkg::S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = tdmq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tdmq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op     = tdmq_pkg::OP_NONE;
        item_stall = 1'b1;
        unique case (state_reg)
            tdmq_pkg::S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.op = tdmq_pkg::OP_LOAD;
                end
            end
            tdmq_pkg::S_POST_A:     cmd.op = tdmq_pkg::OP_POST_A;
            tdmq_pkg::S_POST_B:     cmd.op = tdmq_pkg::OP_POST_B;
            tdmq_pkg::S_INSERT:     cmd.op = tdmq_pkg::OP_INSERT;
            tdmq_pkg::S_TICK:       cmd.op = tdmq_pkg::OP_TICK;
            tdmq_pkg::S_TAKE:       cmd.op = tdmq_pkg::OP_TAKE;
            tdmq_pkg::S_FINISH:     cmd.op = tdmq_pkg::OP_FINISH;
            tdmq_pkg::S_ABORT_INIT: cmd.op = tdmq_pkg::OP_ABORT_INIT;
            tdmq_pkg::S_ABORT_STEP: cmd.op = tdmq_pkg::OP_ABORT_STEP;
            tdmq_pkg::S_RESULT:     cmd.op = tdmq_pkg::OP_RESULT;
            default:                cmd.op = tdmq_pkg::OP_NONE;
        endcase
    end

endmodule

// File: sv/tdmq_datapath.sv
// Datapath for the timed deadline message queue: slot store, list heads,
// list walker, time arithmetic and the result register.
// Depends on tdmq_pkg.
`timescale 1ns / 1ps

module tdmq_datapath #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tdmq_pkg::cmd_t    cmd,
    input  tdmq_pkg::item_t   item,
    output tdmq_pkg::stat_t   stat,
    output logic              result_valid,
    input  logic              result_stall,
    output tdmq_pkg::result_t result
);

    localparam int IXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW  = $clog2(SLOTS + 1);
    localparam int TB  = TIME_BITS;
    localparam logic [SW-1:0] NIL = SW'(SLOTS);
    localparam logic [TB-1:0] INF = {1'b0, {(TB - 1){1'b1}}};

    logic [TB-1:0] base_mem [SLOTS];
    logic [TB-1:0] dead_mem [SLOTS];
    logic [SW-1:0] link_reg [SLOTS];
    logic [1:0]    where_reg [SLOTS];

    logic [SW-1:0] pool_head_reg;
    logic [SW-1:0] timer_head_reg;
    logic [SW-1:0] ready_head_reg;

    tdmq_pkg::item_t item_reg;
    logic [SW-1:0]   s_reg;
    logic [SW-1:0]   q_reg;
    logic [SW-1:0]   prev_reg;
    logic [SW-1:0]   n_reg;
    logic [SW-1:0]   nrel_reg;
    logic [1:0]      lst_reg;
    logic [TB-1:0]   key_reg;
    logic [TB-1:0]   b_reg;
    logic [1:0]      status_reg;
    logic [SW-1:0]   sout_reg;
    logic            wr_reg;
    logic [TB-1:0]   mb_reg;
    logic [TB-1:0]   md_reg;

    logic              out_valid_reg;
    tdmq_pkg::result_t out_reg;

    logic [TB-1:0] now_t;
    logic [TB-1:0] rb_t;
    logic [TB-1:0] rd_t;
    logic [TB-1:0] bo_t;
    logic [TB-1:0] dof_t;
    logic [TB-1:0] cand;
    logic [TB-1:0] b_val;
    logic [TB-1:0] inf_val;
    logic [TB-1:0] d_val;
    logic          to_timer;
    logic [TB-1:0] q_key;
    logic [TB-1:0] tdiff;
    logic          si_ok;
    logic [IXW-1:0] si_ix;
    logic [SW-1:0]  si_p;
    logic [SW-1:0]  lst_head;
    logic [SW-1:0]  where_head;
    logic           out_free;
    logic [3:0]     rel_sat;

    function automatic logic le0(input logic [TB-1:0] a, input logic [TB-1:0] b);
        logic [TB-1:0] d;
        d = a - b;
        return (d == '0) || d[TB-1];
    endfunction

    assign now_t = TB'($signed(item_reg.now));
    assign rb_t  = TB'($signed(item_reg.ref_baseline));
    assign rd_t  = TB'($signed(item_reg.ref_deadline));
    assign bo_t  = TB'($signed(item_reg.base_offset));
    assign dof_t = TB'($signed(item_reg.dead_offset));

    assign cand    = rb_t + bo_t;
    assign b_val   = bo_t[TB-1] ? rb_t : (le0(now_t, cand) ? cand : now_t);
    assign inf_val = (dof_t == '0) ? INF : dof_t;

    always_comb
    begin
        if (item_reg.from_interrupt)
        begin
            d_val = rb_t + (dof_t[TB-1] ? INF : inf_val);
        end
        else
        begin
            d_val = dof_t[TB-1] ? rd_t : (b_reg + inf_val);
        end
    end

    assign to_timer   = !le0(b_reg, now_t);
    assign q_key      = (lst_reg == tdmq_pkg::WHERE_TIMER) ?
                        base_mem[q_reg[IXW-1:0]] : dead_mem[q_reg[IXW-1:0]];
    assign tdiff      = base_mem[timer_head_reg[IXW-1:0]] - now_t;
    assign si_ok      = int'(item_reg.slot_in) < SLOTS;
    assign si_ix      = IXW'(item_reg.slot_in);
    assign si_p       = SW'(item_reg.slot_in);
    assign lst_head   = (lst_reg == tdmq_pkg::WHERE_TIMER) ? timer_head_reg : ready_head_reg;
    assign where_head = (where_reg[si_ix] == tdmq_pkg::WHERE_TIMER) ?
                        timer_head_reg : ready_head_reg;
    assign out_free   = !out_valid_reg || !result_stall;
    assign rel_sat    = (int'(nrel_reg) > 15) ? 4'd15 : 4'(nrel_reg);

    assign stat.kind       = item_reg.kind;
    assign stat.pool_empty = (pool_head_reg == NIL);
    assign stat.insert_go  = (q_reg != NIL) && (int'(n_reg) < SLOTS) && le0(q_key, key_reg);
    assign stat.release_go = (timer_head_reg != NIL) && (int'(nrel_reg) < SLOTS) && tdiff[TB-1];
    assign stat.abort_ok   = si_ok && ((where_reg[si_ix] == tdmq_pkg::WHERE_TIMER) ||
                                       (where_reg[si_ix] == tdmq_pkg::WHERE_READY));
    assign stat.abort_go   = (q_reg != NIL) && (int'(n_reg) < SLOTS) && (q_reg != s_reg);
    assign stat.out_free   = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.op == tdmq_pkg::OP_LOAD)
        begin
            item_reg <= item;
        end
        if (cmd.op == tdmq_pkg::OP_POST_A)
        begin
            b_reg <= b_val;
        end
        if (cmd.op == tdmq_pkg::OP_POST_B)
        begin
            base_mem[s_reg[IXW-1:0]] <= b_reg;
            dead_mem[s_reg[IXW-1:0]] <= d_val;
            key_reg                  <= to_timer ? b_reg : d_val;
        end
        if ((cmd.op == tdmq_pkg::OP_TICK) && stat.release_go)
        begin
            key_reg <= dead_mem[timer_head_reg[IXW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                link_reg[i]  <= SW'(i + 1);
                where_reg[i] <= tdmq_pkg::WHERE_FREE;
            end
            pool_head_reg  <= '0;
            timer_head_reg <= NIL;
            ready_head_reg <= NIL;
            s_reg          <= '0;
            q_reg          <= NIL;
            prev_reg       <= NIL;
            n_reg          <= '0;
            nrel_reg       <= '0;
            lst_reg        <= tdmq_pkg::WHERE_FREE;
            status_reg     <= tdmq_pkg::ST_OK;
            sout_reg       <= '0;
            wr_reg         <= 1'b0;
            mb_reg         <= '0;
            md_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && !result_stall && (cmd.op != tdmq_pkg::OP_RESULT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                tdmq_pkg::OP_LOAD:
                begin
                    status_reg <= tdmq_pkg::ST_OK;
                    sout_reg   <= '0;
                    wr_reg     <= 1'b0;
                    mb_reg     <= '0;
                    md_reg     <= '0;
                    nrel_reg   <= '0;
                end
                tdmq_pkg::OP_POST_A:
                begin
                    if (pool_head_reg == NIL)
                    begin
                        status_reg <= tdmq_pkg::ST_POOL_EMPTY;
                    end
                    else
                    begin
                        s_reg         <= pool_head_reg;
                        pool_head_reg <= link_reg[pool_head_reg[IXW-1:0]];
                    end
                end
                tdmq_pkg::OP_POST_B:
                begin
                    lst_reg  <= to_timer ? tdmq_pkg::WHERE_TIMER : tdmq_pkg::WHERE_READY;
                    wr_reg   <= !to_timer;
                    prev_reg <= NIL;
                    q_reg    <= to_timer ? timer_head_reg : ready_head_reg;
                    n_reg    <= '0;
                    sout_reg <= s_reg;
                    mb_reg   <= b_reg;
                    md_reg   <= d_val;
                end
                tdmq_pkg::OP_INSERT:
                begin
                    if (stat.insert_go)
                    begin
                        prev_reg <= q_reg;
                        q_reg    <= link_reg[q_reg[IXW-1:0]];
                        n_reg    <= n_reg + 1'b1;
                    end
                    else
                    begin
                        link_reg[s_reg[IXW-1:0]]  <= q_reg;
                        where_reg[s_reg[IXW-1:0]] <= lst_reg;
                        if (prev_reg != NIL)
                        begin
                            link_reg[prev_reg[IXW-1:0]] <= s_reg;
                        end
                        else if (lst_reg == tdmq_pkg::WHERE_TIMER)
                        begin
                            timer_head_reg <= s_reg;
                        end
                        else
                        begin
                            ready_head_reg <= s_reg;
                        end
                    end
                end
                tdmq_pkg::OP_TICK:
                begin
                    if (stat.release_go)
                    begin
                        s_reg          <= timer_head_reg;
                        timer_head_reg <= link_reg[timer_head_reg[IXW-1:0]];
                        lst_reg        <= tdmq_pkg::WHERE_READY;
                        prev_reg       <= NIL;
                        q_reg          <= ready_head_reg;
                        n_reg          <= '0;
                        nrel_reg       <= nrel_reg + 1'b1;
                    end
                end
                tdmq_pkg::OP_TAKE:
                begin
                    if (ready_head_reg == NIL)
                    begin
                        status_reg <= tdmq_pkg::ST_READY_EMPTY;
                    end
                    else
                    begin
                        ready_head_reg <= link_reg[ready_head_reg[IXW-1:0]];
                        link_reg[ready_head_reg[IXW-1:0]]  <= NIL;
                        where_reg[ready_head_reg[IXW-1:0]] <= tdmq_pkg::WHERE_TAKEN;
                        sout_reg <= ready_head_reg;
                        mb_reg   <= base_mem[ready_head_reg[IXW-1:0]];
                        md_reg   <= dead_mem[ready_head_reg[IXW-1:0]];
                    end
                end
                tdmq_pkg::OP_FINISH:
                begin
                    if (si_ok && (where_reg[si_ix] == tdmq_pkg::WHERE_TAKEN))
                    begin
                        link_reg[si_ix]  <= pool_head_reg;
                        where_reg[si_ix] <= tdmq_pkg::WHERE_FREE;
                        pool_head_reg    <= si_p;
                    end
                end
                tdmq_pkg::OP_ABORT_INIT:
                begin
                    if (stat.abort_ok)
                    begin
                        s_reg    <= si_p;
                        lst_reg  <= where_reg[si_ix];
                        prev_reg <= NIL;
                        q_reg    <= where_head;
                        n_reg    <= '0;
                    end
                    else
                    begin
                        status_reg <= tdmq_pkg::ST_NOT_QUEUED;
                    end
                end
                tdmq_pkg::OP_ABORT_STEP:
                begin
                    if (stat.abort_go)
                    begin
                        prev_reg <= q_reg;
                        q_reg    <= link_reg[q_reg[IXW-1:0]];
                        n_reg    <= n_reg + 1'b1;
                    end
                    else if (q_reg == s_reg)
                    begin
                        if (prev_reg != NIL)
                        begin
                            link_reg[prev_reg[IXW-1:0]] <= link_reg[s_reg[IXW-1:0]];
                        end
                        else if (lst_reg == tdmq_pkg::WHERE_TIMER)
                        begin
                            timer_head_reg <= link_reg[s_reg[IXW-1:0]];
                        end
                        else
                        begin
                            ready_head_reg <= link_reg[s_reg[IXW-1:0]];
                        end
                        link_reg[s_reg[IXW-1:0]]  <= pool_head_reg;
                        where_reg[s_reg[IXW-1:0]] <= tdmq_pkg::WHERE_FREE;
                        pool_head_reg             <= s_reg;
                    end
                    else
                    begin
                        status_reg <= tdmq_pkg::ST_NOT_QUEUED;
                    end
                end
                tdmq_pkg::OP_RESULT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_reg.status         <= status_reg;
                        out_reg.slot_out       <= 3'(sout_reg);
                        out_reg.went_ready     <= wr_reg;
                        out_reg.msg_baseline   <= 32'($signed(mb_reg));
                        out_reg.msg_deadline   <= 32'($signed(md_reg));
                        out_reg.ready_nonempty <= (ready_head_reg != NIL);
                        out_reg.ready_head_deadline <= (ready_head_reg != NIL) ?
                            32'($signed(dead_mem[ready_head_reg[IXW-1:0]])) : 32'sd0;
                        out_reg.timer_nonempty <= (timer_head_reg != NIL);
                        out_reg.timer_head_baseline <= (timer_head_reg != NIL) ?
                            32'($signed(base_mem[timer_head_reg[IXW-1:0]])) : 32'sd0;
                        out_reg.released       <= (item_reg.kind == tdmq_pkg::KIND_TICK) ?
                                                  rel_sat : 4'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// File: sv/timed_deadline_message_queue.sv
// Top level of the timed deadline message queue scheduler.
// Joins tdmq_ctrl and tdmq_datapath; depends on tdmq_pkg.
//
//   channel   valid          stall          payload
//   request   item_valid     item_stall     item   (tdmq_pkg::item_t)
//   result    result_valid   result_stall   result (tdmq_pkg::result_t)
//
// One request at a time. Post walks k list entries (0..SLOTS) in its sorted insert,
// and skips the insert when the pool is empty. Tick re-inserts each released entry
// into the ready list by the same walk. Abort walks its list to the slot (no walk
// when the slot is not queued); an unknown kind goes straight to the result step.
// The list walk visits one linked slot per cycle. Reset is immediate; no sweep.
// A stalled result holds the block in its result step until it is taken.
`timescale 1ns / 1ps

module timed_deadline_message_queue #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  tdmq_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output tdmq_pkg::result_t result
);

    tdmq_pkg::cmd_t  cmd;
    tdmq_pkg::stat_t stat;

    tdmq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_kind  (item.kind),
        .stat       (stat),
        .cmd        (cmd),
        .item_stall (item_stall)
    );

    tdmq_datapath #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: sv/tdmq_checker.sv
// Port-level checker for the timed deadline message queue.
// Bound to timed_deadline_message_queue; depends on tdmq_pkg.
`timescale 1ns / 1ps

module tdmq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input tdmq_pkg::result_t result
);

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("Stalled result changed.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("Request accepted while another was in progress.");

    a_empty_heads: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.ready_nonempty || result.ready_head_deadline == 0) &&
                          (result.timer_nonempty || result.timer_head_baseline == 0)))
        else $error("Empty list reported a nonzero head time.");

    a_went_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.went_ready) |->
            (result.ready_nonempty && result.status == tdmq_pkg::ST_OK))
        else $error("Post went ready but ready list is empty.");

endmodule

bind timed_deadline_message_queue tdmq_checker u_tdmq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
